// ===== hdl/spe_pkg.sv =====
// ----------------------------------------------------------------------------
// Sparse polynomial evaluator package
// Shared constants, microcode types, step addresses and fixed-point helpers.
// ----------------------------------------------------------------------------
package spe_pkg;

    localparam int TERM_COUNT = 4;
    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int EXPO_W     = 5;
    localparam int REG_TERMS  = 4;
    localparam int TERM_IDX_W = 2;
    localparam int BIT_IDX_W  = 3;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int SUM_W      = DATA_W + TERM_IDX_W;
    localparam int CFG_IDX_W  = 4;
    localparam int STEP_W     = 4;

    typedef logic signed [DATA_W-1:0] q_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic [EXPO_W-1:0]        expo_t;
    typedef logic [TERM_IDX_W-1:0]    term_idx_t;
    typedef logic [BIT_IDX_W-1:0]     bit_idx_t;
    typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
    typedef logic [STEP_W-1:0]        step_t;

    localparam q_t Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam q_t Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam q_t Q_ONE = q_t'(64'd1 << FRAC_BITS);
    localparam bit_idx_t EXPO_TOP = bit_idx_t'(EXPO_W - 1);
    localparam term_idx_t TERM_LAST = term_idx_t'(TERM_COUNT - 1);

    localparam cfg_idx_t REG_COEF_A = cfg_idx_t'(0);
    localparam cfg_idx_t REG_EXPO_A = cfg_idx_t'(1);
    localparam cfg_idx_t REG_COEF_B = cfg_idx_t'(2);
    localparam cfg_idx_t REG_EXPO_B = cfg_idx_t'(3);
    localparam cfg_idx_t REG_COEF_C = cfg_idx_t'(4);
    localparam cfg_idx_t REG_EXPO_C = cfg_idx_t'(5);
    localparam cfg_idx_t REG_COEF_D = cfg_idx_t'(6);
    localparam cfg_idx_t REG_EXPO_D = cfg_idx_t'(7);

    localparam step_t S_IDLE   = step_t'(0);
    localparam step_t S_TERM   = step_t'(1);
    localparam step_t S_SQ     = step_t'(2);
    localparam step_t S_SQW    = step_t'(3);
    localparam step_t S_MX     = step_t'(4);
    localparam step_t S_MXW    = step_t'(5);
    localparam step_t S_BITEND = step_t'(6);
    localparam step_t S_MC     = step_t'(7);
    localparam step_t S_MCW    = step_t'(8);
    localparam step_t S_NEXT   = step_t'(9);
    localparam step_t S_DONE   = step_t'(10);

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_INIT,
        OP_MUL_RR,
        OP_MUL_RX,
        OP_MUL_CR,
        OP_WB_R,
        OP_DEC_BIT,
        OP_ACC,
        OP_INC_TERM,
        OP_DONE
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_START,
        C_COEF_ZERO,
        C_BIT_CLR,
        C_BIT_MORE,
        C_TERM_MORE
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } uword_t;

    typedef struct packed {
        logic coef_zero;
        logic bit_clr;
        logic bit_more;
        logic term_more;
    } dp_status_t;

    typedef struct packed {
        q_t   value;
        logic ovf;
    } sat_t;

    // Floors a product to the fixed-point grid and clamps it to the data range.
    function automatic sat_t sat_prod(input prod_t p);
        prod_t                   q;
        logic [PROD_W-DATA_W:0]  upper;
        sat_t                    res;
        q     = p >>> FRAC_BITS;
        upper = q[PROD_W-1:DATA_W-1];
        res.ovf   = !((&upper) || (~|upper));
        res.value = res.ovf ? (q[PROD_W-1] ? Q_MIN : Q_MAX) : q[DATA_W-1:0];
        return res;
    endfunction

    function automatic sat_t sat_sum(input sum_t s);
        logic [SUM_W-DATA_W:0] upper;
        sat_t                  res;
        upper = s[SUM_W-1:DATA_W-1];
        res.ovf   = !((&upper) || (~|upper));
        res.value = res.ovf ? (s[SUM_W-1] ? Q_MIN : Q_MAX) : s[DATA_W-1:0];
        return res;
    endfunction

endpackage

// ===== hdl/spe_urom.sv =====
// ----------------------------------------------------------------------------
// Sparse polynomial evaluator microcode ROM
// Read-only control program: one control word per step address.
// ----------------------------------------------------------------------------
module spe_urom (
    input  spe_pkg::step_t  pc,
    output spe_pkg::uword_t uword
);
    import spe_pkg::*;

    always_comb
    begin
        unique case (pc)
            S_IDLE:   uword = '{op: OP_LOAD,     cond: C_NO_START,  target: S_IDLE};
            S_TERM:   uword = '{op: OP_INIT,     cond: C_COEF_ZERO, target: S_NEXT};
            S_SQ:     uword = '{op: OP_MUL_RR,   cond: C_NEVER,     target: S_IDLE};
            S_SQW:    uword = '{op: OP_WB_R,     cond: C_BIT_CLR,   target: S_BITEND};
            S_MX:     uword = '{op: OP_MUL_RX,   cond: C_NEVER,     target: S_IDLE};
            S_MXW:    uword = '{op: OP_WB_R,     cond: C_NEVER,     target: S_IDLE};
            S_BITEND: uword = '{op: OP_DEC_BIT,  cond: C_BIT_MORE,  target: S_SQ};
            S_MC:     uword = '{op: OP_MUL_CR,   cond: C_NEVER,     target: S_IDLE};
            S_MCW:    uword = '{op: OP_ACC,      cond: C_NEVER,     target: S_IDLE};
            S_NEXT:   uword = '{op: OP_INC_TERM, cond: C_TERM_MORE, target: S_TERM};
            S_DONE:   uword = '{op: OP_DONE,     cond: C_ALWAYS,    target: S_IDLE};
            default:  uword = '{op: OP_NOP,      cond: C_ALWAYS,    target: S_IDLE};
        endcase
    end

endmodule

// ===== hdl/spe_sequencer.sv =====
// ----------------------------------------------------------------------------
// Sparse polynomial evaluator sequencer
// Step counter with conditional jumps that walks the microcode program.
// ----------------------------------------------------------------------------
module spe_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  spe_pkg::dp_status_t status,
    output spe_pkg::op_t        op,
    output logic                busy
);
    import spe_pkg::*;

    step_t  pc_reg;
    step_t  pc_next;
    uword_t uword;
    logic   take_jump;

    spe_urom u_urom (
        .pc    (pc_reg),
        .uword (uword)
    );

    always_comb
    begin
        unique case (uword.cond)
            C_NEVER:     take_jump = 1'b0;
            C_ALWAYS:    take_jump = 1'b1;
            C_NO_START:  take_jump = !start;
            C_COEF_ZERO: take_jump = status.coef_zero;
            C_BIT_CLR:   take_jump = status.bit_clr;
            C_BIT_MORE:  take_jump = status.bit_more;
            C_TERM_MORE: take_jump = status.term_more;
            default:     take_jump = 1'b1;
        endcase
    end

    always_comb
    begin
        pc_next = take_jump ? uword.target : step_t'(pc_reg + step_t'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign op   = uword.op;
    assign busy = (pc_reg != S_IDLE);

endmodule

// ===== hdl/spe_datapath.sv =====
// ----------------------------------------------------------------------------
// Sparse polynomial evaluator datapath
// Term registers, one shared multiplier, power and sum registers, result output.
// ----------------------------------------------------------------------------
module spe_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  spe_pkg::op_t         op,
    input  spe_pkg::q_t          x_value,
    input  logic                 cfg_we,
    input  spe_pkg::cfg_idx_t    cfg_index,
    input  logic [31:0]          cfg_data,
    output spe_pkg::dp_status_t  status,
    output logic                 done,
    output spe_pkg::q_t          poly_value,
    output logic                 saturated
);
    import spe_pkg::*;

    q_t        coef_reg [REG_TERMS];
    expo_t     expo_reg [REG_TERMS];
    q_t        x_reg;
    q_t        r_reg;
    prod_t     prod_reg;
    sum_t      sum_reg;
    logic      flag_reg;
    bit_idx_t  bit_reg;
    term_idx_t term_reg;
    q_t        out_value_reg;
    logic      out_sat_reg;
    logic      done_reg;

    q_t        mul_a;
    q_t        mul_b;
    prod_t     prod_next;
    sat_t      prod_sat;
    sat_t      sum_sat;
    q_t        coef_cur;
    expo_t     expo_cur;

    assign coef_cur = coef_reg[term_reg];
    assign expo_cur = expo_reg[term_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_TERMS; i++)
            begin
                coef_reg[i] <= '0;
                expo_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COEF_A: coef_reg[0] <= cfg_data;
                REG_EXPO_A: expo_reg[0] <= cfg_data[EXPO_W-1:0];
                REG_COEF_B: coef_reg[1] <= cfg_data;
                REG_EXPO_B: expo_reg[1] <= cfg_data[EXPO_W-1:0];
                REG_COEF_C: coef_reg[2] <= cfg_data;
                REG_EXPO_C: expo_reg[2] <= cfg_data[EXPO_W-1:0];
                REG_COEF_D: coef_reg[3] <= cfg_data;
                REG_EXPO_D: expo_reg[3] <= cfg_data[EXPO_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (op)
            OP_MUL_RR:
            begin
                mul_a = r_reg;
                mul_b = r_reg;
            end
            OP_MUL_RX:
            begin
                mul_a = r_reg;
                mul_b = x_reg;
            end
            default:
            begin
                mul_a = coef_cur;
                mul_b = r_reg;
            end
        endcase
        prod_next = prod_t'(mul_a) * prod_t'(mul_b);
        prod_sat  = sat_prod(prod_reg);
        sum_sat   = sat_sum(sum_reg);
    end

    always_ff @(posedge clk)
    begin
        unique case (op)
            OP_LOAD:
            begin
                x_reg    <= x_value;
                sum_reg  <= '0;
                term_reg <= '0;
            end
            OP_INIT:
            begin
                r_reg   <= Q_ONE;
                bit_reg <= EXPO_TOP;
            end
            OP_MUL_RR, OP_MUL_RX, OP_MUL_CR:
            begin
                prod_reg <= prod_next;
            end
            OP_WB_R:
            begin
                r_reg <= prod_sat.value;
            end
            OP_DEC_BIT:
            begin
                bit_reg <= bit_idx_t'(bit_reg - bit_idx_t'(1));
            end
            OP_ACC:
            begin
                sum_reg <= sum_t'(sum_reg + sum_t'(prod_sat.value));
            end
            OP_INC_TERM:
            begin
                term_reg <= term_idx_t'(term_reg + term_idx_t'(1));
            end
            OP_DONE:
            begin
                out_value_reg <= sum_sat.value;
                out_sat_reg   <= flag_reg | sum_sat.ovf;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (op == OP_DONE);
            if (op == OP_LOAD)
            begin
                flag_reg <= 1'b0;
            end
            else if ((op == OP_WB_R) || (op == OP_ACC))
            begin
                flag_reg <= flag_reg | prod_sat.ovf;
            end
        end
    end

    assign status.coef_zero = (coef_cur == '0);
    assign status.bit_clr   = !expo_cur[bit_reg];
    assign status.bit_more  = (bit_reg != '0);
    assign status.term_more = (term_reg != TERM_LAST);

    assign done       = done_reg;
    assign poly_value = out_value_reg;
    assign saturated  = out_sat_reg;

endmodule

// ===== hdl/sparse_polynomial_evaluator.sv =====
// ----------------------------------------------------------------------------
// Sparse polynomial evaluator
// Evaluates the sum of four coefficient times x to the exponent terms in Q16.16.
// ----------------------------------------------------------------------------
// A transaction starts when start is high while busy is low; x_value is taken
// at that edge. The result appears on poly_value and saturated together with a
// done strobe high for exactly one cycle, and the receiver cannot stall it. All
// multiplies share one multiplier, each as a product step then a floor and
// saturate step, under a microcoded program. A term with a zero coefficient is
// skipped; a present term squares its power once for each exponent bit from the
// top, multiplies by x after the square for each set bit, then multiplies by
// its coefficient and adds into the sum. Busy falls in the cycle done is high,
// and the next transaction may start there. Configuration writes are always
// ready and must be made while busy is low.
module sparse_polynomial_evaluator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  spe_pkg::q_t         x_value,
    output logic                done,
    output spe_pkg::q_t         poly_value,
    output logic                saturated,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  spe_pkg::cfg_idx_t   cfg_index,
    input  logic [31:0]         cfg_data
);
    import spe_pkg::*;

    op_t        op;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    spe_sequencer u_sequencer (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .op     (op),
        .busy   (busy)
    );

    spe_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .x_value    (x_value),
        .cfg_we     (cfg_valid & cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .status     (status),
        .done       (done),
        .poly_value (poly_value),
        .saturated  (saturated)
    );

endmodule

// ===== bench/sparse_polynomial_evaluator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse polynomial evaluator testbench
// Drives evaluation requests and coefficient/exponent writes from a request
// queue, predicts each polynomial value and saturation flag in Q16.16, and
// compares every done strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module sparse_polynomial_evaluator_tb;

    import spe_pkg::*;

    typedef enum logic [1:0] {
        REQ_EVAL,
        REQ_WRITE,
        REQ_DRAIN
    } req_kind_t;

    typedef struct {
        req_kind_t   kind;
        cfg_idx_t    index;
        logic [31:0] data;
        int          gap;
    } request_t;

    typedef struct packed {
        q_t   poly_value;
        logic saturated;
    } poly_result_t;

    localparam int RANDOM_EVALS = 1150;
    localparam int END_CYCLES   = 130;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        start      = 1'b0;
    q_t          x_value    = '0;
    logic        cfg_valid  = 1'b0;
    cfg_idx_t    cfg_index  = '0;
    logic [31:0] cfg_data   = '0;
    logic        busy;
    logic        done;
    q_t          poly_value;
    logic        saturated;
    logic        cfg_ready;

    request_t     request_queue[$];
    poly_result_t predicted_polys[$];
    q_t           coef_shadow[REG_TERMS];
    expo_t        expo_shadow[REG_TERMS];
    int           hold_count;
    int           failures = 0;

    sparse_polynomial_evaluator uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .x_value    (x_value),
        .done       (done),
        .poly_value (poly_value),
        .saturated  (saturated),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic sat_t fixed_mul(input q_t a, input q_t b);
        longint prod;
        longint floored;
        sat_t   res;
        prod      = longint'(a) * longint'(b);
        floored   = prod >>> FRAC_BITS;
        res.ovf   = 1'b0;
        res.value = q_t'(floored);
        if (floored > longint'(Q_MAX))
        begin
            res.ovf   = 1'b1;
            res.value = Q_MAX;
        end
        else if (floored < longint'(Q_MIN))
        begin
            res.ovf   = 1'b1;
            res.value = Q_MIN;
        end
        return res;
    endfunction

    function automatic poly_result_t eval_poly(input q_t x);
        poly_result_t res;
        q_t           power;
        sat_t         step;
        longint       total;
        logic         flag;
        int           k;
        int           b;
        total = 0;
        flag  = 1'b0;
        for (k = 0; k < TERM_COUNT; k++)
        begin
            if (coef_shadow[k] != 0)
            begin
                power = Q_ONE;
                for (b = EXPO_W - 1; b >= 0; b--)
                begin
                    step  = fixed_mul(power, power);
                    flag  = flag | step.ovf;
                    power = step.value;
                    if (expo_shadow[k][b])
                    begin
                        step  = fixed_mul(power, x);
                        flag  = flag | step.ovf;
                        power = step.value;
                    end
                end
                step  = fixed_mul(coef_shadow[k], power);
                flag  = flag | step.ovf;
                total = total + longint'(step.value);
            end
        end
        if (total > longint'(Q_MAX))
        begin
            flag  = 1'b1;
            total = longint'(Q_MAX);
        end
        else if (total < longint'(Q_MIN))
        begin
            flag  = 1'b1;
            total = longint'(Q_MIN);
        end
        res.poly_value = q_t'(total);
        res.saturated  = flag;
        return res;
    endfunction

    function automatic int pick_gap(input bit no_idle);
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 150);
    endfunction

    function automatic q_t pick_extreme();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return Q_ONE;
            2: return -Q_ONE;
            3: return Q_MAX;
            4: return Q_MIN;
            5: return q_t'(1);
            default: return q_t'(-1);
        endcase
    endfunction

    function automatic q_t pick_span(input int unsigned span);
        return q_t'(int'($urandom_range(0, 2 * span)) - int'(span));
    endfunction

    function automatic q_t pick_x();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return pick_extreme();
        else if (r < 50)
            return pick_span(2 * Q_ONE);
        else if (r < 80)
            return pick_span(Q_ONE);
        return q_t'($urandom());
    endfunction

    function automatic q_t pick_coef();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return '0;
        else if (r < 35)
            return pick_extreme();
        else if (r < 75)
            return pick_span(4 * Q_ONE);
        return q_t'($urandom());
    endfunction

    task automatic push_eval(input q_t x, input int gap);
        request_t req;
        req.kind  = REQ_EVAL;
        req.index = '0;
        req.data  = x;
        req.gap   = gap;
        request_queue.insert(request_queue.size(), req);
    endtask

    task automatic push_write(input cfg_idx_t index, input logic [31:0] data);
        request_t req;
        req.kind  = REQ_WRITE;
        req.index = index;
        req.data  = data;
        req.gap   = pick_gap(1'b0);
        request_queue.insert(request_queue.size(), req);
    endtask

    task automatic push_drain(input int gap);
        request_t req;
        req.kind  = REQ_DRAIN;
        req.index = '0;
        req.data  = '0;
        req.gap   = gap;
        request_queue.insert(request_queue.size(), req);
    endtask

    task automatic write_term(input int k, input q_t coef, input logic [31:0] expo);
        case (k)
            0:
            begin
                push_write(REG_COEF_A, coef);
                push_write(REG_EXPO_A, expo);
            end
            1:
            begin
                push_write(REG_COEF_B, coef);
                push_write(REG_EXPO_B, expo);
            end
            2:
            begin
                push_write(REG_COEF_C, coef);
                push_write(REG_EXPO_C, expo);
            end
            default:
            begin
                push_write(REG_COEF_D, coef);
                push_write(REG_EXPO_D, expo);
            end
        endcase
    endtask

    always @(posedge clk)
    begin : driver
        request_t head;
        logic     next_start;
        logic     next_valid;
        if (!rst_n)
        begin
            start      <= 1'b0;
            cfg_valid  <= 1'b0;
            hold_count <= 0;
            for (int k = 0; k < REG_TERMS; k++)
            begin
                coef_shadow[k] = '0;
                expo_shadow[k] = '0;
            end
        end
        else
        begin
            next_start = start;
            next_valid = cfg_valid;
            if (start && !busy)
            begin
                predicted_polys.insert(predicted_polys.size(), eval_poly(x_value));
                next_start = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index <= REG_EXPO_D)
                begin
                    if (!cfg_index[0])
                        coef_shadow[cfg_index[2:1]] = cfg_data;
                    else
                        expo_shadow[cfg_index[2:1]] = cfg_data[EXPO_W-1:0];
                end
                next_valid = 1'b0;
            end
            if (!next_start && !next_valid)
            begin
                if (hold_count != 0)
                    hold_count <= hold_count - 1;
                else if (request_queue.size() != 0)
                begin
                    head = request_queue[0];
                    case (head.kind)
                        REQ_EVAL:
                        begin
                            void'(request_queue.pop_front());
                            next_start = 1'b1;
                            x_value    <= head.data;
                            hold_count <= head.gap;
                        end
                        REQ_WRITE:
                        begin
                            if (predicted_polys.size() == 0)
                            begin
                                void'(request_queue.pop_front());
                                next_valid = 1'b1;
                                cfg_index  <= head.index;
                                cfg_data   <= head.data;
                                hold_count <= head.gap;
                            end
                        end
                        default:
                        begin
                            if (predicted_polys.size() == 0)
                            begin
                                void'(request_queue.pop_front());
                                hold_count <= head.gap;
                            end
                        end
                    endcase
                end
            end
            start     <= next_start;
            cfg_valid <= next_valid;
        end
    end

    always @(posedge clk)
    begin : monitor
        poly_result_t want;
        if (rst_n && done)
        begin
            if (predicted_polys.size() == 0)
            begin
                $error("unexpected transaction: poly_value %0d saturated %0b",
                       poly_value, saturated);
                failures++;
            end
            else
            begin
                want = predicted_polys.pop_front();
                if (poly_value !== want.poly_value)
                begin
                    $error("poly_value mismatch: expected %0d (0x%08h), actual %0d (0x%08h)",
                           want.poly_value, want.poly_value, poly_value, poly_value);
                    failures++;
                end
                if (saturated !== want.saturated)
                begin
                    $error("saturated mismatch: expected %0b, actual %0b",
                           want.saturated, saturated);
                    failures++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int   evals_left;
        int   phase_len;
        int   drain_at;
        int   n;
        int   k;
        bit   no_idle;
        q_t   coef;

        // The polynomial is empty after reset.
        push_eval('0, 0);
        push_eval(Q_MAX, 2);

        write_term(0, Q_ONE, 0);
        write_term(1, Q_ONE, 1);
        write_term(2, Q_MIN, 31);
        write_term(3, Q_MAX, 2);
        push_eval('0, 0);
        push_eval(Q_ONE, 0);
        push_eval(-Q_ONE, 1);
        push_eval(Q_MAX, 0);
        push_eval(Q_MIN, 3);
        push_eval(q_t'(1), 0);
        push_eval(q_t'(-1), 0);
        push_eval(Q_ONE >>> 1, 5);

        // Writes beyond the last register must leave the terms untouched.
        for (k = 1; k <= 8; k++)
            push_write(cfg_idx_t'(REG_EXPO_D + k), $urandom());
        write_term(0, '0, 31);
        write_term(1, -Q_ONE, 3);
        write_term(2, '0, 0);
        write_term(3, q_t'(2 * Q_ONE), 32'hFFFF_FFE0);
        push_eval('0, 0);
        push_eval(Q_MAX, 0);
        push_eval(Q_MIN, 0);
        push_eval(q_t'(3 * Q_ONE), 1);
        push_eval(-Q_ONE, 0);
        push_eval(q_t'(Q_ONE + 1), 0);

        for (k = 0; k < REG_TERMS; k++)
            write_term(k, Q_MAX, 31);
        push_eval(Q_ONE, 0);
        push_eval(-Q_ONE, 0);

        evals_left = RANDOM_EVALS;
        while (evals_left > 0)
        begin
            for (k = 0; k < REG_TERMS; k++)
            begin
                coef = pick_coef();
                if ($urandom_range(0, 1))
                    write_term(k, coef, $urandom_range(0, 4) | ($urandom() & 32'hFFFF_FFE0));
                else
                    write_term(k, coef, $urandom());
            end
            if ($urandom_range(0, 9) == 0)
                push_write(cfg_idx_t'(REG_EXPO_D + $urandom_range(1, 8)), $urandom());
            phase_len = $urandom_range(15, 70);
            if (phase_len > evals_left)
                phase_len = evals_left;
            drain_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, phase_len) : -1;
            no_idle = ($urandom_range(0, 3) == 0);
            for (n = 0; n < phase_len; n++)
            begin
                if (n == drain_at)
                    push_drain($urandom_range(0, 20));
                push_eval(pick_x(), pick_gap(no_idle));
            end
            evals_left = evals_left - phase_len;
        end
        push_drain(0);

        while (request_queue.size() != 0 || start || predicted_polys.size() != 0)
            @(posedge clk);
        repeat (END_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
